// File: src/pfd_pkg.sv
// pfd_pkg: shared codes and controller/datapath structs for the prefix/port filter.
// No dependencies.
package pfd_pkg;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_WPFX  = 2'd1;
  localparam logic [1:0] CMD_WPORT = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] R_PASS    = 3'd0;
  localparam logic [2:0] R_PREFIX  = 3'd1;
  localparam logic [2:0] R_PORT    = 3'd2;
  localparam logic [2:0] R_MALFORM = 3'd3;
  localparam logic [2:0] R_NOTIP   = 3'd4;
  localparam logic [2:0] R_NOTL4   = 3'd5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [6:0]  OFFSET_MAX     = 7'd127;

  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       pscan;
    logic       qscan;
    logic       clr_hit;
    logic       load_verdict;
    logic [2:0] reason;
  } dp_cmd_t;

  typedef struct packed {
    logic       pre_fault;
    logic [2:0] pre_reason;
    logic       phit;
    logic       qhit;
    logic       tcpudp;
    logic       l4_short;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: src/pfd_stream_if.sv
// pfd_req_if / pfd_rsp_if: valid/ready channels for requests and results.
// Depends on nothing.
interface pfd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic [11:0] slot;
  logic [31:0] prefix_addr;
  logic [5:0]  prefix_bits;
  logic [15:0] port_number;
  logic        entry_valid;
  modport source (output valid, cmd, frame_byte, frame_end, slot, prefix_addr,
                  prefix_bits, port_number, entry_valid, input ready);
  modport sink (input valid, cmd, frame_byte, frame_end, slot, prefix_addr,
                prefix_bits, port_number, entry_valid, output ready);
endinterface

interface pfd_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        drop;
  logic [2:0]  reason;
  logic [63:0] counter_value;
  modport source (output valid, result_kind, drop, reason, counter_value, input ready);
  modport sink (input valid, result_kind, drop, reason, counter_value, output ready);
endinterface

// File: src/pfd_ctrl.sv
// pfd_ctrl: sequencer for table clearing, request acceptance and table scans.
// Depends on pfd_pkg.
module pfd_ctrl #(
  parameter int PREFIX_ENTRIES = 4096,
  parameter int PORT_ENTRIES   = 256,
  parameter int CW             = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_cmd,
  input  logic              req_end,
  output logic              req_ready,
  input  pfd_pkg::dp_stat_t stat,
  output pfd_pkg::dp_cmd_t  cmd,
  output logic [CW-1:0]     addr
);

  localparam int MAXE = (PREFIX_ENTRIES > PORT_ENTRIES) ? PREFIX_ENTRIES : PORT_ENTRIES;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_PSCAN = 4'd3;
  localparam logic [3:0] S_PW    = 4'd4;
  localparam logic [3:0] S_PDEC  = 4'd5;
  localparam logic [3:0] S_QSCAN = 4'd6;
  localparam logic [3:0] S_QW    = 4'd7;
  localparam logic [3:0] S_QDEC  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [2:0]    reason, reason_next;
  logic          acc;

  assign addr = idx;
  assign acc  = req_valid && req_ready;

  always_comb begin
    req_ready = (state == S_IDLE) && ((req_cmd != pfd_pkg::CMD_READ) || stat.out_free);
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    reason_next = reason;
    cmd = '0;
    cmd.accept = acc;
    cmd.reason = reason;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (idx == CW'(MAXE - 1)) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (acc && req_cmd == pfd_pkg::CMD_FRAME && req_end) state_next = S_CHECK;
      end
      S_CHECK: begin
        idx_next = '0;
        cmd.clr_hit = 1'b1;
        if (stat.pre_fault) begin
          reason_next = stat.pre_reason;
          state_next  = S_FIN;
        end else begin
          state_next = S_PSCAN;
        end
      end
      S_PSCAN: begin
        cmd.pscan = 1'b1;
        if (idx == CW'(PREFIX_ENTRIES - 1)) begin
          idx_next   = '0;
          state_next = S_PW;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_PW: state_next = S_PDEC;
      S_PDEC: begin
        if (stat.phit) begin
          reason_next = pfd_pkg::R_PREFIX;
          state_next  = S_FIN;
        end else if (!stat.tcpudp) begin
          reason_next = pfd_pkg::R_NOTL4;
          state_next  = S_FIN;
        end else if (stat.l4_short) begin
          reason_next = pfd_pkg::R_MALFORM;
          state_next  = S_FIN;
        end else begin
          state_next = S_QSCAN;
        end
      end
      S_QSCAN: begin
        cmd.qscan = 1'b1;
        if (idx == CW'(PORT_ENTRIES - 1)) begin
          idx_next   = '0;
          state_next = S_QW;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_QW: state_next = S_QDEC;
      S_QDEC: begin
        reason_next = stat.qhit ? pfd_pkg::R_PORT : pfd_pkg::R_PASS;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_verdict = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      reason <= pfd_pkg::R_PASS;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      reason <= reason_next;
    end
  end

endmodule

// File: src/pfd_datapath.sv
// pfd_datapath: header capture, prefix and port memories, scan compare,
// event counters and result register. Depends on pfd_pkg.
module pfd_datapath #(
  parameter int PREFIX_ENTRIES = 4096,
  parameter int PORT_ENTRIES   = 256,
  parameter int CW             = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  pfd_pkg::dp_cmd_t  cmd,
  input  logic [CW-1:0]     addr,
  input  logic [1:0]        req_cmd,
  input  logic [7:0]        frame_byte,
  input  logic              frame_end,
  input  logic [11:0]       slot,
  input  logic [31:0]       prefix_addr,
  input  logic [5:0]        prefix_bits,
  input  logic [15:0]       port_number,
  input  logic              entry_valid,
  output pfd_pkg::dp_stat_t stat,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              result_kind,
  output logic              drop,
  output logic [2:0]        reason,
  output logic [63:0]       counter_value
);

  localparam int PW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
  localparam int QW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

  logic [38:0] pmem [PREFIX_ENTRIES];
  logic [16:0] qmem [PORT_ENTRIES];
  logic [38:0] prd;
  logic [16:0] qrd;
  logic        pcmp, qcmp, phit, qhit;

  logic [6:0]  offset;
  logic [15:0] ethertype;
  logic [3:0]  header_words;
  logic [7:0]  protocol;
  logic [31:0] source_addr;
  logic [15:0] dest_port;
  logic [7:0]  frame_len;
  logic [63:0] cnt [8];

  logic [31:0] slot32, addr32;
  logic [7:0]  pport, need;
  logic [5:0]  bits_c;
  logic [31:0] mask;
  logic        fbyte;

  assign slot32 = 32'(slot);
  assign addr32 = 32'(addr);
  assign fbyte  = cmd.accept && req_cmd == pfd_pkg::CMD_FRAME;
  assign pport  = 8'd16 + {2'b00, header_words, 2'b00};
  assign bits_c = (prefix_bits > 6'd32) ? 6'd32 : prefix_bits;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (addr32 < PREFIX_ENTRIES) pmem[addr[PW-1:0]] <= '0;
    end else if (cmd.accept && req_cmd == pfd_pkg::CMD_WPFX && slot32 < PREFIX_ENTRIES) begin
      pmem[slot32[PW-1:0]] <= {entry_valid, bits_c, prefix_addr};
    end
    if (cmd.pscan) prd <= pmem[addr[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (addr32 < PORT_ENTRIES) qmem[addr[QW-1:0]] <= '0;
    end else if (cmd.accept && req_cmd == pfd_pkg::CMD_WPORT && slot32 < PORT_ENTRIES) begin
      qmem[slot32[QW-1:0]] <= {entry_valid, port_number};
    end
    if (cmd.qscan) qrd <= qmem[addr[QW-1:0]];
  end

  assign mask = (prd[37:32] == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - prd[37:32]));

  always_ff @(posedge clk) begin
    if (rst) begin
      pcmp <= 1'b0;
      qcmp <= 1'b0;
      phit <= 1'b0;
      qhit <= 1'b0;
    end else begin
      pcmp <= cmd.pscan;
      qcmp <= cmd.qscan;
      if (cmd.clr_hit) begin
        phit <= 1'b0;
        qhit <= 1'b0;
      end else begin
        if (pcmp && prd[38] && (((source_addr ^ prd[31:0]) & mask) == 32'h0)) phit <= 1'b1;
        if (qcmp && qrd[16] && qrd[15:0] == dest_port) qhit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset       <= '0;
      ethertype    <= '0;
      header_words <= '0;
      protocol     <= '0;
      source_addr  <= '0;
      dest_port    <= '0;
      frame_len    <= '0;
    end else if (fbyte) begin
      if (offset == 7'd12) ethertype[15:8] <= frame_byte;
      if (offset == 7'd13) ethertype[7:0]  <= frame_byte;
      if (offset == 7'd14) header_words    <= frame_byte[3:0];
      if (offset == 7'd23) protocol        <= frame_byte;
      if (offset == 7'd26) source_addr[31:24] <= frame_byte;
      if (offset == 7'd27) source_addr[23:16] <= frame_byte;
      if (offset == 7'd28) source_addr[15:8]  <= frame_byte;
      if (offset == 7'd29) source_addr[7:0]   <= frame_byte;
      if (offset >= 7'd16 && {1'b0, offset} == pport) dest_port[15:8] <= frame_byte;
      if (offset >= 7'd17 && {1'b0, offset} == pport + 8'd1) dest_port[7:0] <= frame_byte;
      if (frame_end) begin
        frame_len <= {1'b0, offset} + 8'd1;
        offset    <= '0;
      end else if (offset < pfd_pkg::OFFSET_MAX) begin
        offset <= offset + 7'd1;
      end
    end
  end

  assign need = 8'd14 + {2'b00, header_words, 2'b00}
              + ((protocol == pfd_pkg::PROTO_TCP) ? 8'd20 : 8'd8);

  always_comb begin
    stat = '0;
    stat.phit     = phit;
    stat.qhit     = qhit;
    stat.tcpudp   = (protocol == pfd_pkg::PROTO_TCP) || (protocol == pfd_pkg::PROTO_UDP);
    stat.l4_short = frame_len < need;
    stat.out_free = !rsp_valid || rsp_ready;
    if (frame_len < 8'd14) begin
      stat.pre_fault  = 1'b1;
      stat.pre_reason = pfd_pkg::R_MALFORM;
    end else if (ethertype != pfd_pkg::ETHERTYPE_IPV4) begin
      stat.pre_fault  = 1'b1;
      stat.pre_reason = pfd_pkg::R_NOTIP;
    end else if (frame_len < 8'd34) begin
      stat.pre_fault  = 1'b1;
      stat.pre_reason = pfd_pkg::R_MALFORM;
    end
  end

  // counters: frames, prefix, port, passed, malformed, not ip, not l4, unused
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) cnt[i] <= '0;
    end else if (cmd.load_verdict) begin
      cnt[0] <= cnt[0] + 64'd1;
      case (cmd.reason)
        pfd_pkg::R_PREFIX:  cnt[1] <= cnt[1] + 64'd1;
        pfd_pkg::R_PORT:    cnt[2] <= cnt[2] + 64'd1;
        pfd_pkg::R_PASS:    cnt[3] <= cnt[3] + 64'd1;
        pfd_pkg::R_MALFORM: cnt[4] <= cnt[4] + 64'd1;
        pfd_pkg::R_NOTIP:   cnt[5] <= cnt[5] + 64'd1;
        pfd_pkg::R_NOTL4: begin
          cnt[6] <= cnt[6] + 64'd1;
          cnt[3] <= cnt[3] + 64'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_verdict) begin
      rsp_valid     <= 1'b1;
      result_kind   <= 1'b0;
      drop          <= (cmd.reason == pfd_pkg::R_PREFIX) || (cmd.reason == pfd_pkg::R_PORT);
      reason        <= cmd.reason;
      counter_value <= '0;
    end else if (cmd.accept && req_cmd == pfd_pkg::CMD_READ) begin
      rsp_valid     <= 1'b1;
      result_kind   <= 1'b1;
      drop          <= 1'b0;
      reason        <= pfd_pkg::R_PASS;
      counter_value <= (slot < 12'd8) ? cnt[slot[2:0]] : 64'd0;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: src/ipv4_prefix_port_drop_filter.sv
// ipv4_prefix_port_drop_filter: top level, joins controller and datapath.
// Depends on pfd_pkg, pfd_stream_if, pfd_ctrl, pfd_datapath.
//
//  channel  dir  carries
//  req      in   frame bytes, table writes, counter reads
//  rsp      out  frame verdicts and counter read data
//
// Frame bytes, table writes and counter reads are accepted one per cycle when idle.
// A last frame byte leads to a check and, unless it faults, a prefix memory scan over
// all PREFIX_ENTRIES, then, for long enough TCP/UDP frames with no prefix hit, a port
// memory scan over all PORT_ENTRIES, then verdict delivery; no request is accepted
// meanwhile. After reset, a pass clears max(PREFIX_ENTRIES, PORT_ENTRIES) entries.
// A pending result stalls counter reads and verdict delivery only.
module ipv4_prefix_port_drop_filter #(
  parameter int PREFIX_ENTRIES = 4096,
  parameter int PORT_ENTRIES   = 256
) (
  input logic      clk,
  input logic      rst,
  pfd_req_if.sink  req,
  pfd_rsp_if.source rsp
);

  localparam int MAXE = (PREFIX_ENTRIES > PORT_ENTRIES) ? PREFIX_ENTRIES : PORT_ENTRIES;
  localparam int CW   = (MAXE > 1) ? $clog2(MAXE) : 1;

  pfd_pkg::dp_cmd_t  cmd;
  pfd_pkg::dp_stat_t stat;
  logic [CW-1:0]     addr;

  pfd_ctrl #(.PREFIX_ENTRIES(PREFIX_ENTRIES), .PORT_ENTRIES(PORT_ENTRIES), .CW(CW)) u_ctrl (
    .clk, .rst,
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_end   (req.frame_end),
    .req_ready (req.ready),
    .stat, .cmd, .addr
  );

  pfd_datapath #(.PREFIX_ENTRIES(PREFIX_ENTRIES), .PORT_ENTRIES(PORT_ENTRIES), .CW(CW)) u_dp (
    .clk, .rst, .cmd, .addr,
    .req_cmd       (req.cmd),
    .frame_byte    (req.frame_byte),
    .frame_end     (req.frame_end),
    .slot          (req.slot),
    .prefix_addr   (req.prefix_addr),
    .prefix_bits   (req.prefix_bits),
    .port_number   (req.port_number),
    .entry_valid   (req.entry_valid),
    .stat,
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .result_kind   (rsp.result_kind),
    .drop          (rsp.drop),
    .reason        (rsp.reason),
    .counter_value (rsp.counter_value)
  );

endmodule

// File: verif/ipv4_prefix_port_drop_filter_tb.sv
// ipv4_prefix_port_drop_filter_tb: self-checking bench for the prefix/port drop filter.
// Depends on pfd_pkg, pfd_req_if/pfd_rsp_if and ipv4_prefix_port_drop_filter.
// Named tests drive requests in bursts and check every verdict and counter read.
module ipv4_prefix_port_drop_filter_tb;

  localparam int NPFX = 4096;
  localparam int NPORT = 256;
  localparam int IDLE_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 9000;

  typedef struct packed {
    logic        kind;
    logic        drop;
    logic [2:0]  reason;
    logic [63:0] value;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfd_req_if req_ch();
  pfd_rsp_if rsp_ch();

  ipv4_prefix_port_drop_filter uut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted filter state
  logic [6:0]  p_off;
  logic [15:0] p_etype;
  logic [3:0]  p_hwords;
  logic [7:0]  p_proto;
  logic [31:0] p_src;
  logic [15:0] p_dport;
  logic [31:0] pfx_addr [NPFX];
  logic [5:0]  pfx_len [NPFX];
  bit          pfx_on [NPFX];
  logic [15:0] port_val [NPORT];
  bit          port_on [NPORT];
  logic [63:0] event_cnt [8];

  outcome_t outcome_q[$];
  logic [7:0] frame_q[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic bit src_blocked(logic [31:0] a);
    logic [31:0] mask;
    for (int i = 0; i < NPFX; i++) begin
      if (pfx_on[i]) begin
        mask = (pfx_len[i] == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - pfx_len[i]));
        if (((a ^ pfx_addr[i]) & mask) == 32'h0) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit port_blocked(logic [15:0] p);
    for (int i = 0; i < NPORT; i++)
      if (port_on[i] && port_val[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] classify(int len);
    int need;
    event_cnt[0]++;
    if (len < 14) begin event_cnt[4]++; return pfd_pkg::R_MALFORM; end
    if (p_etype != pfd_pkg::ETHERTYPE_IPV4) begin event_cnt[5]++; return pfd_pkg::R_NOTIP; end
    if (len < 34) begin event_cnt[4]++; return pfd_pkg::R_MALFORM; end
    if (src_blocked(p_src)) begin event_cnt[1]++; return pfd_pkg::R_PREFIX; end
    if (p_proto == pfd_pkg::PROTO_TCP || p_proto == pfd_pkg::PROTO_UDP) begin
      need = 14 + p_hwords * 4 + (p_proto == pfd_pkg::PROTO_TCP ? 20 : 8);
      if (len < need) begin event_cnt[4]++; return pfd_pkg::R_MALFORM; end
      if (port_blocked(p_dport)) begin event_cnt[2]++; return pfd_pkg::R_PORT; end
      event_cnt[3]++;
      return pfd_pkg::R_PASS;
    end
    event_cnt[6]++;
    event_cnt[3]++;
    return pfd_pkg::R_NOTL4;
  endfunction

  function automatic void predict_request(logic [1:0] cmd, logic [7:0] b, logic e,
                                          logic [11:0] slot, logic [31:0] addr,
                                          logic [5:0] bits, logic [15:0] port, logic ev);
    int off;
    int pport;
    outcome_t o;
    o = '0;
    if (cmd == pfd_pkg::CMD_FRAME) begin
      off = p_off;
      pport = 14 + p_hwords * 4 + 2;
      if (off == 12) p_etype[15:8] = b;
      if (off == 13) p_etype[7:0] = b;
      if (off == 14) p_hwords = b[3:0];
      if (off == 23) p_proto = b;
      if (off >= 26 && off <= 29) p_src[(29 - off) * 8 +: 8] = b;
      if (off >= 16 && off == pport) p_dport[15:8] = b;
      if (off >= 17 && off == pport + 1) p_dport[7:0] = b;
      if (e) begin
        o.reason = classify(off + 1);
        o.drop = (o.reason == pfd_pkg::R_PREFIX || o.reason == pfd_pkg::R_PORT);
        outcome_q.push_back(o);
        p_off = '0;
      end else if (p_off < pfd_pkg::OFFSET_MAX) begin
        p_off = p_off + 7'd1;
      end
    end else if (cmd == pfd_pkg::CMD_WPFX) begin
      pfx_addr[slot] = addr;
      pfx_len[slot] = (bits > 6'd32) ? 6'd32 : bits;
      pfx_on[slot] = ev;
    end else if (cmd == pfd_pkg::CMD_WPORT) begin
      if (slot < NPORT) begin
        port_val[slot] = port;
        port_on[slot] = ev;
      end
    end else begin
      o.kind = 1'b1;
      o.value = (slot < 8) ? event_cnt[slot] : 64'h0;
      outcome_q.push_back(o);
    end
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic e, logic [11:0] slot,
                              logic [31:0] addr, logic [5:0] bits, logic [15:0] port,
                              logic ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.cmd = cmd;
    req_ch.frame_byte = b;
    req_ch.frame_end = e;
    req_ch.slot = slot;
    req_ch.prefix_addr = addr;
    req_ch.prefix_bits = bits;
    req_ch.port_number = port;
    req_ch.entry_valid = ev;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(cmd, b, e, slot, addr, bits, port, ev);
    burst_left--;
  endtask

  task automatic write_prefix(int slot, logic [31:0] addr, int bits, bit ev);
    send_request(pfd_pkg::CMD_WPFX, 8'($urandom), 1'($urandom), 12'(slot), addr, 6'(bits),
                 16'($urandom), ev);
  endtask

  task automatic write_port(int slot, logic [15:0] port, bit ev);
    send_request(pfd_pkg::CMD_WPORT, 8'($urandom), 1'($urandom), 12'(slot), $urandom,
                 6'($urandom), port, ev);
  endtask

  task automatic read_counter(int slot);
    send_request(pfd_pkg::CMD_READ, 8'($urandom), 1'($urandom), 12'(slot), $urandom,
                 6'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic make_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                            logic [31:0] src, logic [15:0] dport, int len);
    int pport;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    pport = 14 + ihl * 4 + 2;
    if (len > 12) frame_q[12] = etype[15:8];
    if (len > 13) frame_q[13] = etype[7:0];
    if (len > 14) frame_q[14] = {4'h4, ihl};
    if (len > 23) frame_q[23] = proto;
    for (int i = 0; i < 4; i++)
      if (len > 26 + i) frame_q[26 + i] = src[(3 - i) * 8 +: 8];
    if (len > pport) frame_q[pport] = dport[15:8];
    if (len > pport + 1) frame_q[pport + 1] = dport[7:0];
  endtask

  // optionally slips one table write or counter read in mid-frame
  task automatic send_frame(bit mix);
    int at;
    at = mix ? $urandom_range(0, frame_q.size() - 1) : -1;
    foreach (frame_q[i]) begin
      if (i == at) begin
        case ($urandom_range(0, 2))
          0: write_prefix($urandom_range(0, 15), $urandom, $urandom_range(0, 63),
                          1'($urandom));
          1: write_port($urandom_range(0, 300), 16'($urandom), 1'($urandom));
          default: read_counter($urandom_range(0, 9));
        endcase
      end
      send_request(pfd_pkg::CMD_FRAME, frame_q[i], i == frame_q.size() - 1, 12'($urandom),
                   $urandom, 6'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                       logic [31:0] src, logic [15:0] dport, int len);
    make_frame(etype, ihl, proto, src, dport, len);
    send_frame(1'b0);
  endtask

  task automatic test_lengths_and_types();
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd80, 1);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd80, 13);
    frame(16'h86DD, 4'd5, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd80, 20);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'h0102_0304, 16'd80, 33);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd80, 53);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 42);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, 8'd1, 32'h0000_0000, 16'd0, 34);
  endtask

  task automatic test_prefix_rules();
    write_prefix(0, 32'h0A00_0000, 8, 1'b1);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0A01_0203, 16'd80, 54);
    write_prefix(4095, 32'hC0A8_0101, 63, 1'b1);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, 8'd47, 32'hC0A8_0101, 16'd0, 40);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'hC0A8_0100, 16'd0, 42);
    write_prefix(1, 32'h0A00_0000, 8, 1'b1);
    write_prefix(0, 32'h0A00_0000, 8, 1'b0);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0AFF_FFFF, 16'd80, 54);
    write_prefix(1, 32'h0, 0, 1'b0);
    write_prefix(5, 32'h5555_5555, 0, 1'b1);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'h1234_5678, 16'd53, 42);
    write_prefix(5, 32'h0, 0, 1'b0);
  endtask

  task automatic test_port_rules();
    write_port(0, 16'd443, 1'b1);
    write_port(255, 16'hFFFF, 1'b1);
    write_port(256, 16'd53, 1'b1);
    write_port(4095, 16'd53, 1'b1);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd443, 54);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'h0102_0304, 16'hFFFF, 42);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'h0102_0304, 16'd53, 42);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd2, pfd_pkg::PROTO_UDP, 32'h0102_0304, 16'd443, 40);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd0, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd443, 34);
    frame(pfd_pkg::ETHERTYPE_IPV4, 4'd15, pfd_pkg::PROTO_TCP, 32'h0102_0304, 16'd443, 130);
    make_frame(pfd_pkg::ETHERTYPE_IPV4, 4'd5, pfd_pkg::PROTO_UDP, 32'h0102_0304, 16'd443, 42);
    send_frame(1'b1);
    write_port(0, 16'd443, 1'b0);
  endtask

  task automatic test_counter_reads();
    for (int i = 0; i < 8; i++) read_counter(i);
    read_counter(8);
    read_counter(4095);
    send_request(pfd_pkg::CMD_WPORT, 8'hFF, 1'b1, 12'd10, 32'hFFFF_FFFF, 6'h3F, 16'd7, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [15:0] dport;
    int len;
    int base;
    for (int f = 0; f < 3; f++) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 3))
          0: write_prefix(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 15),
                          ($urandom_range(0, 1) == 0) ? {8'h0A, 24'($urandom)} : $urandom,
                          $urandom_range(0, 63), $urandom_range(0, 3) == 0);
          1: write_port(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 7),
                        ($urandom_range(0, 1) == 0) ? 16'($urandom_range(80, 83))
                                                    : 16'($urandom),
                        $urandom_range(0, 2) != 0);
          default: read_counter($urandom_range(0, 9));
        endcase
      end
      etype = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pfd_pkg::ETHERTYPE_IPV4;
      ihl = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd5;
      case ($urandom_range(0, 5))
        0: proto = 8'($urandom);
        1, 2: proto = pfd_pkg::PROTO_UDP;
        default: proto = pfd_pkg::PROTO_TCP;
      endcase
      src = ($urandom_range(0, 2) == 0) ? {8'h0A, 24'($urandom)} : $urandom;
      dport = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(80, 83)) : 16'($urandom);
      base = 14 + ihl * 4 + (proto == pfd_pkg::PROTO_TCP ? 20 : 8);
      if (base < 34) base = 34;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, base);
      else len = base + $urandom_range(0, 6);
      make_frame(etype, ihl, proto, src, dport, len);
      send_frame($urandom_range(0, 3) == 0);
    end
    for (int i = 0; i < 8; i++) read_counter(i);
  endtask

  // result receiver stall pattern
  int stall_period = 1;
  int stall_duty = 1;
  int stall_phase = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 400);
      stall_period = $urandom_range(1, 7);
      stall_duty = ($urandom_range(0, 2) == 0) ? stall_period : $urandom_range(1, stall_period);
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    rsp_ch.ready = !rst && (stall_phase < stall_duty);
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t unexpected result kind=%0d drop=%0d reason=%0d value=%0h", $time,
                 rsp_ch.result_kind, rsp_ch.drop, rsp_ch.reason, rsp_ch.counter_value);
        errors++;
      end else begin
        exp_o = outcome_q.pop_front();
        if (rsp_ch.result_kind !== exp_o.kind || rsp_ch.drop !== exp_o.drop ||
            rsp_ch.reason !== exp_o.reason || rsp_ch.counter_value !== exp_o.value) begin
          $display("%0t expected kind=%0d drop=%0d reason=%0d value=%0h", $time,
                   exp_o.kind, exp_o.drop, exp_o.reason, exp_o.value);
          $display("%0t actual   kind=%0d drop=%0d reason=%0d value=%0h", $time,
                   rsp_ch.result_kind, rsp_ch.drop, rsp_ch.reason, rsp_ch.counter_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("ipv4_prefix_port_drop_filter: mismatch");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = pfd_pkg::CMD_FRAME;
    req_ch.frame_byte = '0;
    req_ch.frame_end = 1'b0;
    req_ch.slot = '0;
    req_ch.prefix_addr = '0;
    req_ch.prefix_bits = '0;
    req_ch.port_number = '0;
    req_ch.entry_valid = 1'b0;
    p_off = '0;
    p_etype = '0;
    p_hwords = '0;
    p_proto = '0;
    p_src = '0;
    p_dport = '0;
    for (int i = 0; i < NPFX; i++) begin
      pfx_addr[i] = '0;
      pfx_len[i] = '0;
      pfx_on[i] = 1'b0;
    end
    for (int i = 0; i < NPORT; i++) begin
      port_val[i] = '0;
      port_on[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) event_cnt[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_lengths_and_types();
    test_prefix_rules();
    test_port_rules();
    test_counter_reads();
    test_random_traffic();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0)
      $display("ipv4_prefix_port_drop_filter: match");
    else
      $display("ipv4_prefix_port_drop_filter: mismatch");
    $finish;
  end

endmodule

// File: files.f
src/pfd_pkg.sv
src/pfd_stream_if.sv
src/pfd_ctrl.sv
src/pfd_datapath.sv
src/ipv4_prefix_port_drop_filter.sv
verif/ipv4_prefix_port_drop_filter_tb.sv
